FILE: design/dual_isa_opcode_class_decoder_assert.svh
// assertion macros for the dual encoding opcode class decoder
// no dependencies; included at the end of the top level body
`ifndef DUAL_ISA_OPCODE_CLASS_DECODER_ASSERT_SVH
`define DUAL_ISA_OPCODE_CLASS_DECODER_ASSERT_SVH

// same cycle implication
`define DIOCD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next cycle implication
`define DIOCD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/diocd_pkg.sv
// shared types and class codes of the dual encoding opcode class decoder
// no dependencies
`timescale 1ns / 1ps

package diocd_pkg;

   typedef logic [5:0] class_type;

   // 32-bit classes
   localparam class_type CLS_BRANCH          = 6'd0;
   localparam class_type CLS_EXCHANGE_REG    = 6'd1;
   localparam class_type CLS_DATA_IMM        = 6'd2;
   localparam class_type CLS_DATA_IMM_SHIFT  = 6'd3;
   localparam class_type CLS_DATA_REG_SHIFT  = 6'd4;
   localparam class_type CLS_LOAD_IMM        = 6'd5;
   localparam class_type CLS_LOAD_REG        = 6'd6;
   localparam class_type CLS_SWAP            = 6'd7;
   localparam class_type CLS_HALF_IMM        = 6'd8;
   localparam class_type CLS_HALF_REG        = 6'd9;
   localparam class_type CLS_MOVE_IMM_OFS    = 6'd10;
   localparam class_type CLS_MOVE_MULTIPLE   = 6'd11;
   localparam class_type CLS_MOVE_REG_OFS    = 6'd12;
   localparam class_type CLS_STATUS_TO_REG   = 6'd13;
   localparam class_type CLS_IMM_TO_STATUS   = 6'd14;
   localparam class_type CLS_REG_TO_STATUS   = 6'd15;
   localparam class_type CLS_MULTIPLY        = 6'd16;
   localparam class_type CLS_MULTIPLY_LONG   = 6'd17;
   localparam class_type CLS_SWI             = 6'd18;

   // 16-bit classes
   localparam class_type CLS_T_ALU           = 6'd19;
   localparam class_type CLS_T_ALU_EXT       = 6'd20;
   localparam class_type CLS_T_ADD_REG       = 6'd21;
   localparam class_type CLS_T_ADJ_IMM       = 6'd22;
   localparam class_type CLS_T_ADJ_REG       = 6'd23;
   localparam class_type CLS_T_ADJ_STACK     = 6'd24;
   localparam class_type CLS_T_BRANCH_EXCH   = 6'd25;
   localparam class_type CLS_T_FAR_PREFIX    = 6'd26;
   localparam class_type CLS_T_FAR_SUFFIX    = 6'd27;
   localparam class_type CLS_T_BRANCH_NEAR   = 6'd28;
   localparam class_type CLS_T_BRANCH_TEST   = 6'd29;
   localparam class_type CLS_T_IMMEDIATE     = 6'd30;
   localparam class_type CLS_T_LOAD_LITERAL  = 6'd31;
   localparam class_type CLS_T_MOVE_BYTE_IMM = 6'd32;
   localparam class_type CLS_T_MOVE_HALF_IMM = 6'd33;
   localparam class_type CLS_T_MOVE_MULTIPLE = 6'd34;
   localparam class_type CLS_T_MOVE_REG_OFS  = 6'd35;
   localparam class_type CLS_T_MOVE_STACK    = 6'd36;
   localparam class_type CLS_T_MOVE_WORD_IMM = 6'd37;
   localparam class_type CLS_T_SHIFT_IMM     = 6'd38;
   localparam class_type CLS_T_SWI           = 6'd39;
   localparam class_type CLS_T_STACK_MULT    = 6'd40;

   typedef struct packed {
      class_type   class_code;
      logic        undefined;
      logic [3:0]  reg_d;
      logic [3:0]  reg_n;
      logic [3:0]  reg_m;
      logic [3:0]  reg_s;
      logic [23:0] immediate;
      logic [3:0]  op_mode;
      logic [1:0]  shift_type;
      logic [4:0]  shift_amount;
      logic [4:0]  flag_bits;
   } decode_result_type;

   localparam decode_result_type RESULT_ZERO = '0;

endpackage

FILE: design/diocd_if.sv
// request and response channel interfaces of the opcode class decoder
// depends on diocd_pkg
`timescale 1ns / 1ps

interface diocd_req_if;
   import diocd_pkg::*;
   logic        valid;
   logic        ready;
   logic [31:0] opcode_word;
   logic        short_encoding;

   modport source (output valid, output opcode_word, output short_encoding, input ready);
   modport sink (input valid, input opcode_word, input short_encoding, output ready);
endinterface

interface diocd_rsp_if;
   import diocd_pkg::*;
   logic        valid;
   logic        ready;
   class_type   class_code;
   logic        undefined;
   logic [3:0]  reg_d;
   logic [3:0]  reg_n;
   logic [3:0]  reg_m;
   logic [3:0]  reg_s;
   logic [23:0] immediate;
   logic [3:0]  op_mode;
   logic [1:0]  shift_type;
   logic [4:0]  shift_amount;
   logic [4:0]  flag_bits;

   modport source (output valid, output class_code, output undefined, output reg_d,
                   output reg_n, output reg_m, output reg_s, output immediate,
                   output op_mode, output shift_type, output shift_amount,
                   output flag_bits, input ready);
   modport sink (input valid, input class_code, input undefined, input reg_d,
                 input reg_n, input reg_m, input reg_s, input immediate,
                 input op_mode, input shift_type, input shift_amount,
                 input flag_bits, output ready);
endinterface

FILE: design/dual_isa_opcode_class_decoder.sv
// top level of the dual encoding opcode class decoder: input register,
// decode logic, result register; depends on diocd_pkg, diocd_if, diocd_wide_dec,
// diocd_short_dec and dual_isa_opcode_class_decoder_assert.svh
//
//   channel   direction   carries
//   req_bus   in          opcode_word, short_encoding
//   rsp_bus   out         class_code, undefined, operand fields
//
// one request per cycle sustained while the response side is ready
// latency is set by the input register and the result register around the decode
// synchronous active high reset empties both stages; payload registers are not reset
// a stalled response holds; an empty input stage still fills while the result waits
`timescale 1ns / 1ps

module dual_isa_opcode_class_decoder (
   input logic   clock,
   input logic   reset,
   diocd_req_if.sink   req_bus,
   diocd_rsp_if.source rsp_bus
);
   import diocd_pkg::*;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [31:0]       s1_opcode_ff;
   logic              s1_short_ff;
   logic              s2_valid_ff;
   logic              s2_valid_in;
   decode_result_type s2_result_ff;
   decode_result_type s2_result_in;
   decode_result_type wide_res;
   decode_result_type short_res;
   logic              s1_load;
   logic              s2_load;

   diocd_wide_dec u_wide (
      .opcode_word (s1_opcode_ff),
      .result      (wide_res)
   );

   diocd_short_dec u_short (
      .opcode_half (s1_opcode_ff[15:0]),
      .result      (short_res)
   );

   assign s2_load      = !s2_valid_ff || rsp_bus.ready;
   assign s1_load      = !s1_valid_ff || s2_load;
   assign s1_valid_in  = s1_load ? req_bus.valid : s1_valid_ff;
   assign s2_valid_in  = s2_load ? s1_valid_ff : s2_valid_ff;
   assign s2_result_in = s1_short_ff ? short_res : wide_res;

   assign req_bus.ready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_bus.valid) begin
         s1_opcode_ff <= req_bus.opcode_word;
         s1_short_ff  <= req_bus.short_encoding;
      end
      if (s2_load && s1_valid_ff) begin
         s2_result_ff <= s2_result_in;
      end
   end

   assign rsp_bus.valid        = s2_valid_ff;
   assign rsp_bus.class_code   = s2_result_ff.class_code;
   assign rsp_bus.undefined    = s2_result_ff.undefined;
   assign rsp_bus.reg_d        = s2_result_ff.reg_d;
   assign rsp_bus.reg_n        = s2_result_ff.reg_n;
   assign rsp_bus.reg_m        = s2_result_ff.reg_m;
   assign rsp_bus.reg_s        = s2_result_ff.reg_s;
   assign rsp_bus.immediate    = s2_result_ff.immediate;
   assign rsp_bus.op_mode      = s2_result_ff.op_mode;
   assign rsp_bus.shift_type   = s2_result_ff.shift_type;
   assign rsp_bus.shift_amount = s2_result_ff.shift_amount;
   assign rsp_bus.flag_bits    = s2_result_ff.flag_bits;

`include "dual_isa_opcode_class_decoder_assert.svh"

   `DIOCD_ASSERT_IMP(a_undef_zero, clock, reset, s2_valid_ff && s2_result_ff.undefined, s2_result_ff[55:0] == 56'd0 && s2_result_ff.class_code == CLS_BRANCH, "undefined result carries nonzero fields")
   `DIOCD_ASSERT_IMP(a_class_range, clock, reset, s2_valid_ff, s2_result_ff.class_code <= CLS_T_STACK_MULT, "class code out of range")
   `DIOCD_ASSERT_NXT(a_stage_advance, clock, reset, s1_valid_ff && s2_load, s2_valid_ff, "decoded request lost between stages")
   `DIOCD_ASSERT_IMP(a_short_flags, clock, reset, s2_valid_ff && s2_result_ff.class_code > CLS_SWI, s2_result_ff.flag_bits[4:1] == 4'd0, "16-bit class with wide flag bits")

endmodule

FILE: design/diocd_wide_dec.sv
// class and operand field decode of a 32-bit encoded opcode
// depends on diocd_pkg
`timescale 1ns / 1ps

module diocd_wide_dec (
   input  logic [31:0]                  opcode_word,
   output diocd_pkg::decode_result_type result
);
   import diocd_pkg::*;

   logic [31:0]       w;
   logic [3:0]        alu;
   logic              save;
   logic [7:0]        hi;
   logic [3:0]        lo;
   logic [4:0]        pos;
   logic              cmp;
   logic              bound;
   class_type         cls;
   decode_result_type r;

   assign w    = opcode_word;
   assign alu  = w[24:21];
   assign save = w[20];
   assign hi   = w[27:20];
   assign lo   = w[7:4];
   assign pos  = w[24:20];
   assign cmp  = (alu[3:2] == 2'b10) && !save;

   // class selection
   always_comb begin
      bound = 1'b0;
      cls   = CLS_BRANCH;
      unique case (w[27:25])
         3'd5: begin
            bound = 1'b1;
            cls   = CLS_BRANCH;
         end
         3'd7: begin
            bound = w[24];
            cls   = CLS_SWI;
         end
         3'd4: begin
            bound = 1'b1;
            cls   = CLS_MOVE_MULTIPLE;
         end
         3'd2: begin
            bound = 1'b1;
            cls   = CLS_MOVE_IMM_OFS;
         end
         3'd3: begin
            bound = !lo[0];
            cls   = CLS_MOVE_REG_OFS;
         end
         3'd1: begin
            if (!cmp) begin
               bound = 1'b1;
               cls   = CLS_DATA_IMM;
            end else if (w[21]) begin
               bound = 1'b1;
               cls   = CLS_IMM_TO_STATUS;
            end
         end
         3'd0: begin
            if (!(lo[0] && lo[3])) begin
               if (!cmp) begin
                  bound = 1'b1;
                  cls   = lo[0] ? CLS_DATA_REG_SHIFT : CLS_DATA_IMM_SHIFT;
               end else if (lo == 4'd0) begin
                  bound = 1'b1;
                  cls   = w[21] ? CLS_REG_TO_STATUS : CLS_STATUS_TO_REG;
               end else if (lo == 4'd1 && hi == 8'h12) begin
                  bound = 1'b1;
                  cls   = CLS_EXCHANGE_REG;
               end
            end else begin
               unique case (lo[2:1])
                  2'd0: begin
                     if (w[27:22] == 6'd0) begin
                        bound = 1'b1;
                        cls   = CLS_MULTIPLY;
                     end else if (w[27:23] == 5'd1) begin
                        bound = 1'b1;
                        cls   = CLS_MULTIPLY_LONG;
                     end else if ((hi & 8'hfb) == 8'h10) begin
                        bound = 1'b1;
                        cls   = CLS_SWAP;
                     end
                  end
                  2'd1: begin
                     bound = 1'b1;
                     cls   = w[22] ? CLS_HALF_IMM : CLS_HALF_REG;
                  end
                  default: begin
                     bound = save;
                     cls   = w[22] ? CLS_LOAD_IMM : CLS_LOAD_REG;
                  end
               endcase
            end
         end
         default: begin
            bound = 1'b0;
         end
      endcase
   end

   // operand fields of the chosen class
   always_comb begin
      r = RESULT_ZERO;
      r.class_code = cls;
      unique case (cls)
         CLS_BRANCH: begin
            r.immediate = w[23:0];
            r.flag_bits = {4'd0, w[24]};
         end
         CLS_EXCHANGE_REG: begin
            r.reg_m = w[3:0];
         end
         CLS_DATA_IMM, CLS_IMM_TO_STATUS: begin
            r.immediate    = {16'd0, w[7:0]};
            r.shift_amount = {1'b0, w[11:8]};
            if (cls == CLS_DATA_IMM) begin
               r.reg_d     = w[15:12];
               r.reg_n     = w[19:16];
               r.flag_bits = {4'd0, save};
               r.op_mode   = alu;
            end else begin
               r.op_mode   = w[19:16];
               r.flag_bits = pos & 5'h04;
            end
         end
         CLS_DATA_IMM_SHIFT, CLS_DATA_REG_SHIFT: begin
            r.reg_m      = w[3:0];
            r.shift_type = w[6:5];
            if (cls == CLS_DATA_IMM_SHIFT) begin
               r.shift_amount = w[11:7];
            end else begin
               r.reg_s = w[11:8];
            end
            r.reg_d     = w[15:12];
            r.reg_n     = w[19:16];
            r.flag_bits = {4'd0, save};
            r.op_mode   = alu;
         end
         CLS_LOAD_IMM, CLS_LOAD_REG: begin
            if (cls == CLS_LOAD_IMM) begin
               r.immediate = {16'd0, w[11:8], w[3:0]};
            end else begin
               r.reg_m = w[3:0];
            end
            r.reg_d     = w[15:12];
            r.reg_n     = w[19:16];
            r.flag_bits = (pos & 5'h1a) | {2'd0, w[5], 2'd0};
         end
         CLS_SWAP: begin
            r.reg_m     = w[3:0];
            r.reg_d     = w[15:12];
            r.reg_n     = w[19:16];
            r.flag_bits = pos & 5'h04;
         end
         CLS_HALF_IMM, CLS_HALF_REG: begin
            if (cls == CLS_HALF_IMM) begin
               r.immediate = {16'd0, w[11:8], w[3:0]};
            end else begin
               r.reg_m = w[3:0];
            end
            r.reg_d     = w[15:12];
            r.reg_n     = w[19:16];
            r.flag_bits = pos & 5'h1b;
         end
         CLS_MOVE_IMM_OFS: begin
            r.immediate = {12'd0, w[11:0]};
            r.reg_d     = w[15:12];
            r.reg_n     = w[19:16];
            r.flag_bits = pos;
         end
         CLS_MOVE_MULTIPLE: begin
            r.immediate = {8'd0, w[15:0]};
            r.reg_n     = w[19:16];
            r.flag_bits = pos;
         end
         CLS_MOVE_REG_OFS: begin
            r.reg_m        = w[3:0];
            r.shift_type   = w[6:5];
            r.shift_amount = w[11:7];
            r.reg_d        = w[15:12];
            r.reg_n        = w[19:16];
            r.flag_bits    = pos;
         end
         CLS_STATUS_TO_REG: begin
            r.reg_d     = w[15:12];
            r.flag_bits = pos & 5'h04;
         end
         CLS_REG_TO_STATUS: begin
            r.reg_m     = w[3:0];
            r.op_mode   = w[19:16];
            r.flag_bits = pos & 5'h04;
         end
         CLS_MULTIPLY, CLS_MULTIPLY_LONG: begin
            r.reg_m     = w[3:0];
            r.reg_s     = w[11:8];
            r.reg_n     = w[15:12];
            r.reg_d     = w[19:16];
            r.flag_bits = pos & ((cls == CLS_MULTIPLY) ? 5'h03 : 5'h07);
         end
         default: begin
            r.immediate = w[23:0];
         end
      endcase
   end

   always_comb begin
      if (bound) begin
         result = r;
      end else begin
         result           = RESULT_ZERO;
         result.undefined = 1'b1;
      end
   end

endmodule

FILE: design/diocd_short_dec.sv
// class and operand field decode of a 16-bit encoded opcode
// depends on diocd_pkg
`timescale 1ns / 1ps

module diocd_short_dec (
   input  logic [15:0]                  opcode_half,
   output diocd_pkg::decode_result_type result
);
   import diocd_pkg::*;

   logic [15:0]       w;
   logic [2:0]        d3;
   logic [2:0]        b3;
   logic [2:0]        b6;
   logic [2:0]        r8;
   logic [7:0]        i8;
   logic              m11;
   logic              bound;
   decode_result_type r;

   assign w   = opcode_half;
   assign d3  = w[2:0];
   assign b3  = w[5:3];
   assign b6  = w[8:6];
   assign r8  = w[10:8];
   assign i8  = w[7:0];
   assign m11 = w[11];

   always_comb begin
      r     = RESULT_ZERO;
      bound = 1'b1;
      unique case (w[15:12])
         4'd0, 4'd1: begin
            r.reg_d = {1'b0, d3};
            if (w[12:11] != 2'd3) begin
               r.class_code = CLS_T_SHIFT_IMM;
               r.reg_m      = {1'b0, b3};
               r.immediate  = {19'd0, w[10:6]};
               r.op_mode    = {2'd0, w[12:11]};
            end else begin
               r.reg_n   = {1'b0, b3};
               r.op_mode = {3'd0, w[9]};
               if (w[10]) begin
                  r.class_code = CLS_T_ADJ_IMM;
                  r.immediate  = {21'd0, b6};
               end else begin
                  r.class_code = CLS_T_ADJ_REG;
                  r.reg_m      = {1'b0, b6};
               end
            end
         end
         4'd2, 4'd3: begin
            r.class_code = CLS_T_IMMEDIATE;
            r.immediate  = {16'd0, i8};
            r.reg_d      = {1'b0, r8};
            r.op_mode    = {2'd0, w[12:11]};
         end
         4'd4: begin
            priority if (m11) begin
               r.class_code = CLS_T_LOAD_LITERAL;
               r.immediate  = {16'd0, i8};
               r.reg_d      = {1'b0, r8};
            end else if (!w[10]) begin
               r.class_code = CLS_T_ALU;
               r.reg_d      = {1'b0, d3};
               r.reg_m      = {1'b0, b3};
               r.op_mode    = w[9:6];
            end else if (w[9:8] != 2'd3) begin
               r.class_code = CLS_T_ALU_EXT;
               r.reg_d      = {w[7], d3};
               r.reg_m      = w[6:3];
               r.op_mode    = {2'd0, w[9:8]};
            end else if (!w[7]) begin
               r.class_code = CLS_T_BRANCH_EXCH;
               r.reg_m      = w[6:3];
            end else begin
               bound = 1'b0;
            end
         end
         4'd5: begin
            r.class_code = CLS_T_MOVE_REG_OFS;
            r.reg_d      = {1'b0, d3};
            r.reg_n      = {1'b0, b3};
            r.reg_m      = {1'b0, b6};
            r.op_mode    = {1'b0, w[11:9]};
         end
         4'd6, 4'd7, 4'd8: begin
            unique case (w[13:12])
               2'd2:    r.class_code = CLS_T_MOVE_WORD_IMM;
               2'd3:    r.class_code = CLS_T_MOVE_BYTE_IMM;
               default: r.class_code = CLS_T_MOVE_HALF_IMM;
            endcase
            r.reg_d     = {1'b0, d3};
            r.reg_n     = {1'b0, b3};
            r.immediate = {19'd0, w[10:6]};
            r.op_mode   = {3'd0, m11};
         end
         4'd9, 4'd10: begin
            r.class_code = w[13] ? CLS_T_ADD_REG : CLS_T_MOVE_STACK;
            r.immediate  = {16'd0, i8};
            r.reg_d      = {1'b0, r8};
            r.op_mode    = {3'd0, m11};
         end
         4'd11: begin
            priority if (w[11:8] == 4'd0) begin
               r.class_code = CLS_T_ADJ_STACK;
               r.immediate  = {17'd0, w[6:0]};
               r.op_mode    = {3'd0, w[7]};
            end else if (w[10:9] == 2'd2) begin
               r.class_code = CLS_T_STACK_MULT;
               r.immediate  = {16'd0, i8};
               r.flag_bits  = {4'd0, w[8]};
               r.op_mode    = {3'd0, m11};
            end else begin
               bound = 1'b0;
            end
         end
         4'd12: begin
            r.class_code = CLS_T_MOVE_MULTIPLE;
            r.immediate  = {16'd0, i8};
            r.reg_n      = {1'b0, r8};
            r.op_mode    = {3'd0, m11};
         end
         4'd13: begin
            r.immediate = {16'd0, i8};
            if (w[11:8] == 4'd15) begin
               r.class_code = CLS_T_SWI;
            end else begin
               r.class_code = CLS_T_BRANCH_TEST;
               r.op_mode    = w[11:8];
            end
         end
         4'd14: begin
            r.class_code = CLS_T_BRANCH_NEAR;
            r.immediate  = {13'd0, w[10:0]};
            bound        = !m11;
         end
         default: begin
            r.class_code = m11 ? CLS_T_FAR_SUFFIX : CLS_T_FAR_PREFIX;
            r.immediate  = {13'd0, w[10:0]};
         end
      endcase
   end

   always_comb begin
      if (bound) begin
         result = r;
      end else begin
         result           = RESULT_ZERO;
         result.undefined = 1'b1;
      end
   end

endmodule
